@@ design/bounded_list_insert_delete_dump_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bounded list block
// Concurrent assertion wrappers clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_INSERT_DELETE_DUMP_TOP_MACROS_SVH
`define BOUNDED_LIST_INSERT_DELETE_DUMP_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define BLID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define BLID_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define BLID_ASSERT(label, prop, msg)
`define BLID_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

@@ design/blid_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded list package
// Shared constants, command codes and the result word type.
// ----------------------------------------------------------------------------
package blid_pkg;

    localparam int BLID_CAPACITY = 32;
    localparam int OPCODE_W      = 2;
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 16;

    localparam logic [OPCODE_W-1:0] OP_INSERT_FRONT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_APPEND_BACK  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE_POS   = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] element;
        logic                      is_last;
        logic                      list_empty;
        logic                      insert_dropped;
    } out_word_t;

endpackage

@@ design/blid_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module blid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/bounded_list_insert_delete_dump_top.sv @@
// ----------------------------------------------------------------------------
// Bounded list with insert, append, delete and dump
// Keeps up to CAPACITY signed values in a circular buffer held in one RAM.
// ----------------------------------------------------------------------------
// Each input word carries one command: insert at the front, append at the
// back, or delete at a position. After every command the whole list is sent
// on the result channel, front to back, one word per element, with the last
// word flagged. An empty list gives a single word marked empty.
// An insert into a list that is not full is written to the RAM in the cycle
// it is accepted. A delete is carried out during the dump: each element
// behind the deleted one is read from one place further on and written back
// one place nearer the front. The first result word passes through the RAM
// read register and then the output register. Without back-pressure one word
// leaves per cycle; the next command is taken once the last element of the
// dump has been read, as the single RAM read port reads one element per cycle.
// The output register and a skid register hold results while the receiver
// stalls; reads stop when both are full, and a new command is accepted while
// earlier results are still waiting.
// Reset empties the list and clears all handshake state; the RAM is not
// cleared, as only entries below the count are ever read.
// ----------------------------------------------------------------------------
`include "bounded_list_insert_delete_dump_top_macros.svh"

module bounded_list_insert_delete_dump_top #(
    parameter int CAPACITY = blid_pkg::BLID_CAPACITY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [blid_pkg::OPCODE_W-1:0]       s_opcode,
    input  logic signed [blid_pkg::VALUE_W-1:0] s_element_value,
    input  logic [blid_pkg::POS_W-1:0]          s_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [blid_pkg::VALUE_W-1:0] m_list_element,
    output logic                                m_is_last,
    output logic                                m_list_empty,
    output logic                                m_insert_dropped
);

    import blid_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                                 input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(CAPACITY)) begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    logic            state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   head_reg, head_next;
    logic            del_reg, del_next;
    logic [CW-1:0]   del_pos_reg, del_pos_next;
    logic            dropped_reg, dropped_next;
    logic [CW-1:0]   iss_reg, iss_next;
    logic            inf_v_reg, inf_v_next;
    logic            inf_last_reg, inf_last_next;
    logic            inf_empty_reg, inf_empty_next;
    logic            inf_wb_reg, inf_wb_next;
    logic [CW-1:0]   inf_idx_reg, inf_idx_next;
    out_word_t       out_reg, out_next;
    logic            out_v_reg, out_v_next;
    out_word_t       skid_reg, skid_next;
    logic            skid_v_reg, skid_v_next;

    logic            in_acc;
    logic            out_acc;
    logic            full;
    logic            is_insert;
    logic [AW-1:0]   head_m1;
    logic            issue;
    logic            shift;
    logic [CW-1:0]   rd_logical;
    logic [1:0]      occupancy;
    logic            last_k;
    out_word_t       incoming;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    blid_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE) && !inf_v_reg;
    assign in_acc    = s_valid && s_ready;
    assign out_acc   = out_v_reg && m_ready;
    assign full      = (count_reg == CW'(CAPACITY));
    assign is_insert = (s_opcode == OP_INSERT_FRONT) || (s_opcode == OP_APPEND_BACK);
    assign head_m1   = (head_reg == '0) ? AW'(CAPACITY - 1) : head_reg - 1'b1;

    assign occupancy  = 2'(out_v_reg) + 2'(skid_v_reg) + 2'(inf_v_reg);
    assign issue      = (state_reg == ST_DUMP) && (occupancy <= 2'(1) + 2'(out_acc));
    assign shift      = del_reg && (iss_reg >= del_pos_reg);
    assign rd_logical = iss_reg + CW'(shift);
    assign last_k     = (count_reg == '0) || (iss_reg == count_reg - 1'b1);

    assign ram_re    = issue && (count_reg != '0);
    assign ram_raddr = phys_addr(head_reg, rd_logical);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = phys_addr(head_reg, inf_idx_reg);
        ram_wdata = ram_rdata;
        if (inf_v_reg && inf_wb_reg) begin
            ram_we = 1'b1;
        end else if (in_acc && is_insert && !full) begin
            ram_we    = 1'b1;
            ram_wdata = s_element_value;
            if (s_opcode == OP_INSERT_FRONT) begin
                ram_waddr = head_m1;
            end else begin
                ram_waddr = phys_addr(head_reg, count_reg);
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        del_next       = del_reg;
        del_pos_next   = del_pos_reg;
        dropped_next   = dropped_reg;
        iss_next       = iss_reg;
        inf_v_next     = 1'b0;
        inf_last_next  = inf_last_reg;
        inf_empty_next = inf_empty_reg;
        inf_wb_next    = inf_wb_reg;
        inf_idx_next   = inf_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next   = ST_DUMP;
                    iss_next     = '0;
                    del_next     = 1'b0;
                    dropped_next = is_insert && full;
                    if (is_insert && !full) begin
                        count_next = count_reg + 1'b1;
                        if (s_opcode == OP_INSERT_FRONT) begin
                            head_next = head_m1;
                        end
                    end else if (s_opcode == OP_DELETE_POS &&
                                 s_position < POS_W'(count_reg)) begin
                        del_next     = 1'b1;
                        del_pos_next = s_position[CW-1:0];
                        count_next   = count_reg - 1'b1;
                    end
                end
            end
            ST_DUMP: begin
                if (issue) begin
                    inf_v_next     = 1'b1;
                    inf_last_next  = last_k;
                    inf_empty_next = (count_reg == '0);
                    inf_wb_next    = shift;
                    inf_idx_next   = iss_reg;
                    iss_next       = iss_reg + 1'b1;
                    if (last_k) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        incoming.element        = inf_empty_reg ? '0 : ram_rdata;
        incoming.is_last        = inf_last_reg;
        incoming.list_empty     = inf_empty_reg;
        incoming.insert_dropped = dropped_reg;

        out_next    = out_reg;
        out_v_next  = out_v_reg;
        skid_next   = skid_reg;
        skid_v_next = skid_v_reg;

        if (skid_v_reg) begin
            if (out_acc) begin
                out_next    = skid_reg;
                skid_next   = incoming;
                skid_v_next = inf_v_reg;
            end
        end else if (!out_v_reg || out_acc) begin
            out_next   = incoming;
            out_v_next = inf_v_reg;
        end else if (inf_v_reg) begin
            skid_next   = incoming;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            head_reg   <= '0;
            del_reg    <= 1'b0;
            iss_reg    <= '0;
            inf_v_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            head_reg   <= head_next;
            del_reg    <= del_next;
            iss_reg    <= iss_next;
            inf_v_reg  <= inf_v_next;
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        del_pos_reg   <= del_pos_next;
        dropped_reg   <= dropped_next;
        inf_last_reg  <= inf_last_next;
        inf_empty_reg <= inf_empty_next;
        inf_wb_reg    <= inf_wb_next;
        inf_idx_reg   <= inf_idx_next;
        out_reg       <= out_next;
        skid_reg      <= skid_next;
    end

    assign m_valid          = out_v_reg;
    assign m_list_element   = out_reg.element;
    assign m_is_last        = out_reg.is_last;
    assign m_list_empty     = out_reg.list_empty;
    assign m_insert_dropped = out_reg.insert_dropped;

    `BLID_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "Element count exceeds capacity.")
    `BLID_ASSERT_IMPL(a_skid_behind_out, skid_v_reg, out_v_reg, "Skid word held without an output word.")
    `BLID_ASSERT_IMPL(a_no_overflow, skid_v_reg && inf_v_reg, out_acc, "Read data arrived with no free slot.")
    `BLID_ASSERT_IMPL(a_wb_only_on_delete, inf_v_reg && inf_wb_reg, del_reg && !s_ready, "Write-back outside a delete dump.")

endmodule

@@ tb/sv/tb_bounded_list_insert_delete_dump_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the bounded list with insert, append, delete and dump
// Commands go in on the input channel and every dump word is checked against
// a shadow copy of the list, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_bounded_list_insert_delete_dump_top;
    timeunit 1ns;
    timeprecision 1ps;

    import blid_pkg::*;

    localparam int CAPACITY = BLID_CAPACITY;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [OPCODE_W-1:0]        s_opcode = '0;
    logic signed [VALUE_W-1:0]  s_element_value = '0;
    logic [POS_W-1:0]           s_position = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [VALUE_W-1:0]  m_list_element;
    logic                       m_is_last;
    logic                       m_list_empty;
    logic                       m_insert_dropped;

    logic signed [VALUE_W-1:0]  shadow_list [CAPACITY];
    int                         shadow_len = 0;
    out_word_t                  pending_words [$];

    int n_errors = 0;
    int n_words = 0;
    int n_front = 0;
    int n_back = 0;
    int n_delete = 0;
    int n_unused = 0;
    int n_dropped = 0;
    int n_out_of_range = 0;
    int longest = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    bounded_list_insert_delete_dump_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_element_value  (s_element_value),
        .s_position       (s_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_list_element   (m_list_element),
        .m_is_last        (m_is_last),
        .m_list_empty     (m_list_empty),
        .m_insert_dropped (m_insert_dropped)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Applies one command to the shadow list and queues the dump it causes.
    function automatic void apply_command(input logic [OPCODE_W-1:0] op,
                                          input logic signed [VALUE_W-1:0] value,
                                          input logic [POS_W-1:0] pos);
        logic      dropped;
        out_word_t w;
        dropped = 1'b0;
        case (op) inside
            OP_INSERT_FRONT, OP_APPEND_BACK: begin
                if (shadow_len >= CAPACITY) begin
                    dropped = 1'b1;
                    n_dropped++;
                end else if (op == OP_INSERT_FRONT) begin
                    for (int i = shadow_len; i > 0; i--) begin
                        shadow_list[i] = shadow_list[i-1];
                    end
                    shadow_list[0] = value;
                    shadow_len++;
                end else begin
                    shadow_list[shadow_len] = value;
                    shadow_len++;
                end
                if (op == OP_INSERT_FRONT) begin
                    n_front++;
                end else begin
                    n_back++;
                end
            end
            OP_DELETE_POS: begin
                n_delete++;
                if (int'(pos) < shadow_len) begin
                    for (int i = int'(pos); i + 1 < shadow_len; i++) begin
                        shadow_list[i] = shadow_list[i+1];
                    end
                    shadow_len--;
                end else begin
                    n_out_of_range++;
                end
            end
            default: begin
                n_unused++;
            end
        endcase
        if (shadow_len > longest) begin
            longest = shadow_len;
        end
        if (shadow_len == 0) begin
            w.element        = '0;
            w.is_last        = 1'b1;
            w.list_empty     = 1'b1;
            w.insert_dropped = dropped;
            pending_words.push_back(w);
        end else begin
            for (int k = 0; k < shadow_len; k++) begin
                w.element        = shadow_list[k];
                w.is_last        = (k + 1 == shadow_len);
                w.list_empty     = 1'b0;
                w.insert_dropped = dropped;
                pending_words.push_back(w);
            end
        end
    endfunction

    // Valid is left high on return so that a following word may go out at once.
    task automatic send_command(input logic [OPCODE_W-1:0] op,
                                input logic signed [VALUE_W-1:0] value,
                                input logic [POS_W-1:0] pos);
        int gap;
        if ($urandom_range(0, 24) == 0) begin
            tx_steady = !tx_steady;
        end
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_element_value <= value;
        s_position      <= pos;
        do @(posedge aclk); while (!s_ready);
        apply_command(op, value, pos);
    endtask

    task automatic wait_for_dump;
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int        stall;
        out_word_t got;
        out_word_t want;
        @(posedge aclk iff aresetn);
        forever begin
            if ($urandom_range(0, 24) == 0) begin
                rx_steady = !rx_steady;
            end
            stall = rx_steady ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = '{m_list_element, m_is_last, m_list_empty, m_insert_dropped};
            n_words++;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %0d, element %0d",
                                          n_words, got.element));
            end else begin
                want = pending_words.pop_front();
                if (got.element !== want.element) begin
                    report_mismatch($sformatf("word %0d element %0d, expected %0d",
                                              n_words, got.element, want.element));
                end
                if (got.is_last !== want.is_last) begin
                    report_mismatch($sformatf("word %0d is_last %b, expected %b",
                                              n_words, got.is_last, want.is_last));
                end
                if (got.list_empty !== want.list_empty) begin
                    report_mismatch($sformatf("word %0d list_empty %b, expected %b",
                                              n_words, got.list_empty, want.list_empty));
                end
                if (got.insert_dropped !== want.insert_dropped) begin
                    report_mismatch($sformatf("word %0d insert_dropped %b, expected %b",
                                              n_words, got.insert_dropped,
                                              want.insert_dropped));
                end
            end
        end
    end

    task automatic test_empty_list;
        send_command(OP_DELETE_POS, $urandom, 16'd0);
        send_command(OP_DELETE_POS, $urandom, 16'hFFFF);
        send_command(OP_UNUSED, 32'sh7FFF_FFFF, 16'hFFFF);
        wait_for_dump;
    endtask

    task automatic test_directed_edits;
        send_command(OP_INSERT_FRONT, 32'sh7FFF_FFFF, 16'hFFFF);
        send_command(OP_APPEND_BACK, 32'sh8000_0000, 16'h0000);
        send_command(OP_INSERT_FRONT, -32'sd1, 16'h5555);
        send_command(OP_APPEND_BACK, 32'sd0, 16'hAAAA);
        send_command(OP_DELETE_POS, 32'sh5A5A_5A5A, 16'd4);
        send_command(OP_DELETE_POS, 32'sd0, 16'd1);
        send_command(OP_UNUSED, 32'sh1234_5678, 16'd0);
        send_command(OP_DELETE_POS, 32'sd0, 16'd2);
        send_command(OP_DELETE_POS, 32'sd0, 16'd0);
        send_command(OP_DELETE_POS, 32'sd0, 16'd0);
        send_command(OP_APPEND_BACK, 32'sd1, 16'h8000);
        send_command(OP_DELETE_POS, -32'sd1, 16'h8000);
        send_command(OP_DELETE_POS, 32'sd0, 16'd0);
        send_command(OP_INSERT_FRONT, 32'sh8000_0000, 16'd0);
        wait_for_dump;
    endtask

    task automatic test_full_list;
        while (shadow_len < CAPACITY) begin
            send_command($urandom_range(0, 1) ? OP_APPEND_BACK : OP_INSERT_FRONT,
                         $urandom, POS_W'($urandom));
        end
        send_command(OP_INSERT_FRONT, $urandom, POS_W'($urandom));
        send_command(OP_APPEND_BACK, $urandom, POS_W'($urandom));
        send_command(OP_UNUSED, $urandom, POS_W'($urandom));
        send_command(OP_DELETE_POS, $urandom, 16'(CAPACITY));
        send_command(OP_DELETE_POS, $urandom, 16'(CAPACITY - 1));
        send_command(OP_APPEND_BACK, $urandom, POS_W'($urandom));
        send_command(OP_DELETE_POS, $urandom, 16'd0);
        send_command(OP_INSERT_FRONT, $urandom, POS_W'($urandom));
        send_command(OP_APPEND_BACK, $urandom, POS_W'($urandom));
        send_command(OP_DELETE_POS, $urandom, 16'(CAPACITY / 2));
        wait_for_dump;
    endtask

    // Alternates growing and shrinking spells so the list swings between
    // empty and full.
    task automatic test_random_traffic(input int n_items);
        bit                  growing;
        int                  pick;
        logic [OPCODE_W-1:0] op;
        logic [POS_W-1:0]    pos;
        growing = 1'b1;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                growing = !growing;
            end
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                op = OP_UNUSED;
            end else if (pick < (growing ? 76 : 28)) begin
                op = $urandom_range(0, 1) ? OP_APPEND_BACK : OP_INSERT_FRONT;
            end else begin
                op = OP_DELETE_POS;
            end
            pick = $urandom_range(0, 9);
            if (op != OP_DELETE_POS || pick == 0) begin
                pos = POS_W'($urandom);
            end else if (pick == 1) begin
                pos = POS_W'(shadow_len);
            end else if (pick == 2) begin
                pos = POS_W'($urandom_range(shadow_len, 2 * CAPACITY));
            end else begin
                pos = (shadow_len == 0) ? '0 : POS_W'($urandom_range(0, shadow_len - 1));
            end
            send_command(op, $urandom, pos);
            if ($urandom_range(0, 59) == 0) begin
                wait_for_dump;
            end
        end
        wait_for_dump;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_list();
        test_directed_edits();
        test_full_list();
        test_random_traffic(370);
        repeat (40) @(posedge aclk);
        $display("Sent %0d front inserts, %0d appends, %0d deletes and %0d unused codes.",
                 n_front, n_back, n_delete, n_unused);
        $display("%0d inserts hit a full list, %0d deletes missed, %0d words, longest %0d.",
                 n_dropped, n_out_of_range, n_words, longest);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/blid_pkg.sv
design/blid_ram.sv
design/bounded_list_insert_delete_dump_top.sv
tb/sv/tb_bounded_list_insert_delete_dump_top.sv
